// ===== sv/abhw_pkg.sv =====
// shared types and constants for the archive block header walker
// no dependencies; used by every module of the block by scoped names
package abhw_pkg;

  // width of the file counter (range 8 to 32)
  localparam int unsigned CountBits = 16;

  localparam logic [7:0]  FileType     = 8'h74;
  localparam logic [4:0]  BlockHeadLen = 5'd7;
  localparam logic [4:0]  FileHeadLen  = 5'd25;
  localparam logic [32:0] SigLen       = 33'd7;
  // block head plus file head, consumed before the name and the data
  localparam logic [33:0] FileUsedLen  = 34'd32;

  // byte offsets inside the block head and the file head
  localparam logic [4:0] HeadTypeIdx   = 5'd2;
  localparam logic [4:0] HeadSizeLoIdx = 5'd5;
  localparam logic [4:0] HeadSizeHiIdx = 5'd6;
  localparam logic [4:0] FilePackBytes = 5'd4;
  localparam logic [4:0] FileNameLoIdx = 5'd19;
  localparam logic [4:0] FileNameHiIdx = 5'd20;

  // result kinds
  localparam logic KindName  = 1'b0;
  localparam logic KindCount = 1'b1;

  // result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    PhSig,
    PhHead,
    PhFile,
    PhName,
    PhSkip
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [15:0] out_value;
    logic        out_last;
  } out_item_t;

  // up to two results caused by one accepted byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  typedef struct packed {
    logic [QCntW-1:0] fill;
    logic             room;
  } q_stat_t;

endpackage

// ===== sv/archive_block_header_walker.sv =====
// archive block header walker: one archive byte per transfer
// output: each byte's results are registered in the result queue and leave from its head in order
// throughput: one byte per cycle; stalls only when three or more results wait
// reset: asynchronous active low, walk restarts at the signature, queue empties
// depends on abhw_pkg, abhw_walker, abhw_out_queue
module archive_block_header_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  abhw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output abhw_pkg::out_item_t out_data_o
);

  // a byte transfer updates the parse state in the same edge; its results
  // (a name byte, the final file count, or both) land in the result queue
  logic              take;
  abhw_pkg::push_t   push;
  abhw_pkg::q_stat_t q_stat;

  // ready depends only on queue fill, never on the output side this cycle
  assign in_ready_o = q_stat.room;
  assign take       = in_valid_i && in_ready_o;

  abhw_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .push_o (push)
  );

  abhw_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .stat_o      (q_stat)
  );

  // queue never overfills
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.fill <= abhw_pkg::QCntW'(abhw_pkg::QDepth))
    else $error("result queue overfilled");

  // the final byte always yields the count result
  a_final_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_data_i.final_byte) |=> out_valid_o)
    else $error("no result after final byte");

  // no result appears without a byte transfer
  a_no_invent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!take && !out_valid_o) |=> !out_valid_o)
    else $error("result without input transfer");

  // a count result pushed with a name byte always comes second
  a_push_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (push.first.out_kind == abhw_pkg::KindName &&
                           push.second.out_kind == abhw_pkg::KindCount))
    else $error("result order broken");

endmodule

// ===== sv/abhw_walker.sv =====
// block chain walker: parse state and per-byte field update
// depends on abhw_pkg
module abhw_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  abhw_pkg::in_item_t item_i,
  output abhw_pkg::push_t    push_o
);

  abhw_pkg::phase_e                  phase_q, phase_d;
  logic [4:0]                        idx_q, idx_d;
  logic [7:0]                        type_q, type_d;
  logic [15:0]                       hsize_q, hsize_d;
  logic [31:0]                       pack_q, pack_d;
  logic [15:0]                       nlen_q, nlen_d;
  logic [32:0]                       skip_q, skip_d;
  logic [abhw_pkg::CountBits-1:0]    files_q, files_d;
  logic [32:0]                       tail_q, tail_d;

  logic [7:0]        b;
  logic [15:0]       hs_full;
  logic [32:0]       hs_skip;
  logic [33:0]       tail_diff;
  logic [32:0]       tail_skip;
  logic [32:0]       skip_dec;
  logic              skip_go;
  logic [32:0]       skip_amt;
  logic [31:0]       cnt_ext;
  abhw_pkg::out_item_t name_res;
  abhw_pkg::out_item_t cnt_res;

  always_comb begin
    b         = item_i.data_byte;
    hs_full   = {b, hsize_q[7:0]};
    hs_skip   = (hs_full > 16'(abhw_pkg::BlockHeadLen)) ?
                33'(hs_full - 16'(abhw_pkg::BlockHeadLen)) : '0;
    tail_diff = {1'b0, tail_q} - (34'(nlen_q) + abhw_pkg::FileUsedLen);
    tail_skip = tail_diff[33] ? '0 : tail_diff[32:0];
    skip_dec  = (skip_q == '0) ? '0 : skip_q - 33'd1;

    name_res.out_kind  = abhw_pkg::KindName;
    name_res.out_value = {8'd0, b};
    name_res.out_last  = (skip_q <= 33'd1);

    phase_d  = phase_q;
    idx_d    = idx_q;
    type_d   = type_q;
    hsize_d  = hsize_q;
    pack_d   = pack_q;
    nlen_d   = nlen_q;
    skip_d   = skip_q;
    files_d  = files_q;
    tail_d   = tail_q;
    skip_go  = 1'b0;
    skip_amt = '0;
    push_o   = '0;

    if (take_i) begin
      case (phase_q)
        abhw_pkg::PhSig, abhw_pkg::PhSkip: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = abhw_pkg::PhHead;
            idx_d   = '0;
          end
        end
        abhw_pkg::PhHead: begin
          if (idx_q == abhw_pkg::HeadTypeIdx) begin
            type_d = b;
            if (b == abhw_pkg::FileType && files_q != {abhw_pkg::CountBits{1'b1}}) begin
              files_d = files_q + 1'b1;
            end
          end else if (idx_q == abhw_pkg::HeadSizeLoIdx) begin
            hsize_d = {8'd0, b};
          end else if (idx_q == abhw_pkg::HeadSizeHiIdx) begin
            hsize_d = hs_full;
          end
          idx_d = idx_q + 5'd1;
          if (idx_q == abhw_pkg::BlockHeadLen - 5'd1) begin
            idx_d = '0;
            if (type_q == abhw_pkg::FileType) begin
              phase_d = abhw_pkg::PhFile;
              pack_d  = '0;
              nlen_d  = '0;
            end else begin
              skip_go  = 1'b1;
              skip_amt = hs_skip;
            end
          end
        end
        abhw_pkg::PhFile: begin
          if (idx_q < abhw_pkg::FilePackBytes) begin
            pack_d[{idx_q[1:0], 3'b000} +: 8] = b;
          end else if (idx_q == abhw_pkg::FileNameLoIdx) begin
            nlen_d = {8'd0, b};
          end else if (idx_q == abhw_pkg::FileNameHiIdx) begin
            nlen_d = {b, nlen_q[7:0]};
          end
          // pack size is complete from offset four on
          tail_d = 33'(hsize_q) + 33'(pack_q);
          idx_d  = idx_q + 5'd1;
          if (idx_q == abhw_pkg::FileHeadLen - 5'd1) begin
            idx_d = '0;
            if (nlen_q == '0) begin
              skip_go  = 1'b1;
              skip_amt = tail_skip;
            end else begin
              phase_d = abhw_pkg::PhName;
              skip_d  = 33'(nlen_q);
            end
          end
        end
        abhw_pkg::PhName: begin
          push_o.cnt   = 2'd1;
          push_o.first = name_res;
          skip_d       = skip_dec;
          if (skip_dec == '0) begin
            skip_go  = 1'b1;
            skip_amt = tail_skip;
          end
        end
        default: begin
          phase_d = abhw_pkg::PhHead;
          idx_d   = '0;
        end
      endcase

      if (skip_go) begin
        if (skip_amt == '0) begin
          phase_d = abhw_pkg::PhHead;
          idx_d   = '0;
        end else begin
          phase_d = abhw_pkg::PhSkip;
          skip_d  = skip_amt;
        end
      end
    end

    cnt_ext           = 32'(files_d);
    cnt_res.out_kind  = abhw_pkg::KindCount;
    cnt_res.out_value = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
    cnt_res.out_last  = 1'b1;

    if (take_i && item_i.final_byte) begin
      if (push_o.cnt == 2'd1) begin
        push_o.second = cnt_res;
        push_o.cnt    = 2'd2;
      end else begin
        push_o.first = cnt_res;
        push_o.cnt   = 2'd1;
      end
      phase_d = abhw_pkg::PhSig;
      idx_d   = '0;
      type_d  = '0;
      hsize_d = '0;
      pack_d  = '0;
      nlen_d  = '0;
      skip_d  = abhw_pkg::SigLen;
      files_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= abhw_pkg::PhSig;
      idx_q   <= '0;
      type_q  <= '0;
      hsize_q <= '0;
      pack_q  <= '0;
      nlen_q  <= '0;
      skip_q  <= abhw_pkg::SigLen;
      files_q <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      type_q  <= type_d;
      hsize_q <= hsize_d;
      pack_q  <= pack_d;
      nlen_q  <= nlen_d;
      skip_q  <= skip_d;
      files_q <= files_d;
    end
  end

  // scratch sum, only read after it is loaded in the file head
  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
  end

endmodule

// ===== sv/abhw_out_queue.sv =====
// collapsing result queue: takes up to two results per cycle, head drives the port
// depends on abhw_pkg
module abhw_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abhw_pkg::push_t     push_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output abhw_pkg::out_item_t out_data_o,
  output abhw_pkg::q_stat_t   stat_o
);

  abhw_pkg::out_item_t             ent_q [abhw_pkg::QDepth];
  abhw_pkg::out_item_t             ent_d [abhw_pkg::QDepth];
  logic [abhw_pkg::QCntW-1:0]      fill_q, fill_d;
  logic [abhw_pkg::QCntW-1:0]      base;
  logic                            pop;

  assign pop  = (fill_q != '0) && out_ready_i;
  assign base = fill_q - abhw_pkg::QCntW'(pop);

  always_comb begin
    fill_d = base + abhw_pkg::QCntW'(push_i.cnt);
  end

  for (genvar i = 0; i < abhw_pkg::QDepth; i++) begin : g_ent
    abhw_pkg::out_item_t shifted;
    if (i < abhw_pkg::QDepth - 1) begin : g_mid
      assign shifted = pop ? ent_q[i+1] : ent_q[i];
    end else begin : g_top
      assign shifted = ent_q[i];
    end
    always_comb begin
      ent_d[i] = shifted;
      if (push_i.cnt != 2'd0 && base == abhw_pkg::QCntW'(i)) begin
        ent_d[i] = push_i.first;
      end else if (push_i.cnt == 2'd2 && base + 1'b1 == abhw_pkg::QCntW'(i)) begin
        ent_d[i] = push_i.second;
      end
    end
    always_ff @(posedge clk_i) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = ent_q[0];
  // room for the two results a final byte can cause
  assign stat_o.fill = fill_q;
  assign stat_o.room = (fill_q <= abhw_pkg::QCntW'(abhw_pkg::QDepth - 2));

endmodule
